### hdl/lbm_pkg.sv
// Package for the link bandwidth meter.
// Holds the item types and the fixed field widths; no dependencies.
`default_nettype none

package lbm_pkg;

    localparam int BYTES_W = 16;
    localparam int TIME_W  = 48;
    localparam int RATE_W  = 40;
    localparam int COUNT_W = 32;
    localparam int FILL_W  = 7;
    localparam int SCALE_W = 18;

    // bytes per microsecond to kB/s with 8 fraction bits
    localparam logic [SCALE_W-1:0] RATE_SCALE = 18'd256000;

    localparam logic [RATE_W-1:0]  RATE_MAX  = {RATE_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TIME_W-1:0]  TOTAL_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic [BYTES_W-1:0] packet_bytes;
        logic [TIME_W-1:0]  arrival_us;
    } pkt_item_t;

    typedef struct packed {
        logic [RATE_W-1:0]  instant_rate;
        logic [RATE_W-1:0]  average_rate;
        logic [RATE_W-1:0]  peak_rate;
        logic [COUNT_W-1:0] packet_count;
        logic [TIME_W-1:0]  byte_total;
        logic [FILL_W-1:0]  window_fill;
    } rpt_item_t;

    typedef struct packed {
        logic [BYTES_W-1:0] packet_bytes;
        logic [TIME_W-1:0]  arrival_us;
        logic [COUNT_W-1:0] packet_count;
        logic [TIME_W-1:0]  byte_total;
    } queue_item_t;

endpackage

`default_nettype wire

### hdl/link_bandwidth_meter.sv
// Top level of the link bandwidth meter: front end, queue and back end.
// Depends on lbm_pkg, lbm_front and lbm_back.
//
//   channel | valid     | stall     | payload
//   packets | pkt_valid | pkt_stall | pkt (lbm_pkg::pkt_item_t)
//   reports | rpt_valid | rpt_stall | rpt (lbm_pkg::rpt_item_t)
//
// Each item in the back end takes NUM_W bits of serial division, then one
// read of the peak ring per entry. Two items queue ahead of the back end.
// Reset clears all control state at once; the rings need no clearing pass.
// A stalled report holds while the back end goes on with the next item.
`default_nettype none

module link_bandwidth_meter #(
    parameter int AVG_WINDOW  = 64,
    parameter int PEAK_WINDOW = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                pkt_valid,
    output logic                     pkt_stall,
    input  wire lbm_pkg::pkt_item_t  pkt,
    output logic                     rpt_valid,
    input  wire logic                rpt_stall,
    output lbm_pkg::rpt_item_t       rpt
);

    logic                 q_valid;
    logic                 q_pop;
    lbm_pkg::queue_item_t q_item;

    lbm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item)
    );

    lbm_back #(.AVG_WINDOW(AVG_WINDOW), .PEAK_WINDOW(PEAK_WINDOW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .rpt_valid (rpt_valid),
        .rpt_stall (rpt_stall),
        .rpt       (rpt)
    );

`ifndef SYNTH
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid |-> rpt.packet_count != '0)
        else $error("report with zero packet count");

    a_peak_covers_avg: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid |-> rpt.peak_rate >= rpt.average_rate)
        else $error("peak below average");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

### hdl/lbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/lbm_div.sv
// Restoring bit-serial divider, one quotient bit per cycle, saturating
// to the rate field. Depends on lbm_pkg.
`default_nettype none

module lbm_div #(
    parameter int NUM_W = 41
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [NUM_W-1:0]            num,
    input  wire logic [lbm_pkg::TIME_W-1:0]  den,
    output logic                             busy,
    output logic      [lbm_pkg::RATE_W-1:0]  quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]           num_reg;
    logic [lbm_pkg::TIME_W-1:0] rem_reg;
    logic [lbm_pkg::TIME_W-1:0] den_reg;
    logic                       zero_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [lbm_pkg::TIME_W:0]   trial;
    logic [lbm_pkg::TIME_W:0]   diff;
    logic                       qbit;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign qbit  = (trial >= {1'b0, den_reg});
    assign busy  = (cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(NUM_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            rem_reg  <= '0;
            den_reg  <= den;
            zero_reg <= (den == '0);
        end
        else if (busy)
        begin
            num_reg <= {num_reg[NUM_W-2:0], qbit};
            rem_reg <= qbit ? diff[lbm_pkg::TIME_W-1:0] : trial[lbm_pkg::TIME_W-1:0];
        end
    end

    always_comb
    begin
        if (zero_reg)
        begin
            quot = '0;
        end
        else if (|num_reg[NUM_W-1:lbm_pkg::RATE_W])
        begin
            quot = lbm_pkg::RATE_MAX;
        end
        else
        begin
            quot = num_reg[lbm_pkg::RATE_W-1:0];
        end
    end

endmodule

`default_nettype wire

### hdl/lbm_front.sv
// Front end: accepts packet items, keeps the saturating totals and
// queues items for the back end in a two-entry queue. Depends on lbm_pkg.
`default_nettype none

module lbm_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pkt_valid,
    output logic                       pkt_stall,
    input  wire lbm_pkg::pkt_item_t    pkt,
    output logic                       q_valid,
    input  wire logic                  q_pop,
    output lbm_pkg::queue_item_t       q_item
);

    lbm_pkg::queue_item_t       ent_reg [2];
    logic                       wptr_reg;
    logic                       rptr_reg;
    logic [1:0]                 cnt_reg;
    logic [lbm_pkg::COUNT_W-1:0] count_reg;
    logic [lbm_pkg::TIME_W-1:0] total_reg;
    logic [lbm_pkg::COUNT_W-1:0] count_next;
    logic [lbm_pkg::TIME_W-1:0] total_next;
    logic [lbm_pkg::TIME_W:0]   total_sum;
    logic                       push;
    logic                       pop;

    assign pkt_stall = (cnt_reg == 2'd2);
    assign push      = pkt_valid && !pkt_stall;
    assign q_valid   = (cnt_reg != 2'd0);
    assign pop       = q_pop && q_valid;
    assign q_item    = ent_reg[rptr_reg];

    assign total_sum  = {1'b0, total_reg} + (lbm_pkg::TIME_W + 1)'(pkt.packet_bytes);
    assign total_next = total_sum[lbm_pkg::TIME_W] ? lbm_pkg::TOTAL_MAX
                                                   : total_sum[lbm_pkg::TIME_W-1:0];
    assign count_next = (count_reg == lbm_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            cnt_reg   <= 2'd0;
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg  <= !wptr_reg;
                count_reg <= count_next;
                total_reg <= total_next;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= '{packet_bytes: pkt.packet_bytes,
                                   arrival_us:   pkt.arrival_us,
                                   packet_count: count_next,
                                   byte_total:   total_next};
        end
    end

endmodule

`default_nettype wire

### hdl/lbm_back.sv
// Back end: window rings, two serial dividers, peak scan and the
// report register. Depends on lbm_pkg, lbm_ram and lbm_div.
`default_nettype none

module lbm_back #(
    parameter int AVG_WINDOW  = 64,
    parameter int PEAK_WINDOW = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    output logic                       q_pop,
    input  wire lbm_pkg::queue_item_t  q_item,
    output logic                       rpt_valid,
    input  wire logic                  rpt_stall,
    output lbm_pkg::rpt_item_t         rpt
);

    localparam int AW    = $clog2(AVG_WINDOW);
    localparam int FW    = $clog2(AVG_WINDOW + 1);
    localparam int PAW   = (PEAK_WINDOW > 1) ? $clog2(PEAK_WINDOW) : 1;
    localparam int PFW   = $clog2(PEAK_WINDOW + 1);
    localparam int SUM_W = lbm_pkg::BYTES_W + AW;
    localparam int PROD_W = SUM_W + lbm_pkg::SCALE_W;
    localparam int NUM_W = (PROD_W > lbm_pkg::RATE_W) ? PROD_W : lbm_pkg::RATE_W + 1;
    localparam logic [AW-1:0] HEAD_LAST = AW'(AVG_WINDOW - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(AVG_WINDOW);
    localparam logic [PAW-1:0] RHEAD_LAST = PAW'(PEAK_WINDOW - 1);
    localparam logic [PFW-1:0] RFILL_FULL = PFW'(PEAK_WINDOW);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RDA  = 9'b000000010,
        S_RDB  = 9'b000000100,
        S_UPD  = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_WRR  = 9'b001000000,
        S_SCAN = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    lbm_pkg::queue_item_t       item_reg;
    logic [AW-1:0]              head_reg;
    logic [FW-1:0]              fill_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [PAW-1:0]             rhead_reg;
    logic [PFW-1:0]             rfill_reg;
    logic [PFW-1:0]             scan_reg;
    logic                       scan_vld_reg;
    logic [lbm_pkg::BYTES_W-1:0] old_size_reg;
    logic [lbm_pkg::TIME_W-1:0] tprev_reg;
    logic [lbm_pkg::TIME_W-1:0] toldest_reg;
    logic [lbm_pkg::RATE_W-1:0] inst_reg;
    logic [lbm_pkg::RATE_W-1:0] avg_reg;
    logic [lbm_pkg::RATE_W-1:0] peak_reg;
    logic                       rpt_valid_reg;
    lbm_pkg::rpt_item_t         rpt_reg;

    logic [AW-1:0]              head_new;
    logic [AW-1:0]              prev_idx;
    logic [FW-1:0]              fill_new;
    logic [FW:0]                oldest_wide;
    logic [AW-1:0]              oldest_idx;
    logic                       full;
    logic [lbm_pkg::BYTES_W-1:0] size_rdata;
    logic [lbm_pkg::TIME_W-1:0] time_rdata;
    logic [AW-1:0]              time_raddr;
    logic [lbm_pkg::RATE_W-1:0] rate_rdata;
    logic [lbm_pkg::RATE_W-1:0] avg_val;
    logic [SUM_W-1:0]           rest_sum;
    logic [NUM_W-1:0]           num_i;
    logic [NUM_W-1:0]           num_a;
    logic [lbm_pkg::TIME_W-1:0] den_i;
    logic [lbm_pkg::TIME_W-1:0] den_a;
    logic                       div_start;
    logic                       busy_i;
    logic                       busy_a;
    logic [lbm_pkg::RATE_W-1:0] quot_i;
    logic [lbm_pkg::RATE_W-1:0] quot_a;
    logic                       two_rec;
    logic                       load_out;

    assign full     = (fill_reg == FILL_FULL);
    assign fill_new = full ? fill_reg : fill_reg + 1'b1;
    assign head_new = (head_reg == HEAD_LAST) ? '0 : head_reg + 1'b1;
    assign prev_idx = (head_reg == '0) ? HEAD_LAST : head_reg - 1'b1;
    assign oldest_wide = ((FW + 1)'(head_new) >= (FW + 1)'(fill_new))
                       ? (FW + 1)'(head_new) - (FW + 1)'(fill_new)
                       : (FW + 1)'(head_new) + (FW + 1)'(AVG_WINDOW) - (FW + 1)'(fill_new);
    assign oldest_idx = oldest_wide[AW-1:0];
    assign time_raddr = (state_reg == S_RDB) ? oldest_idx : prev_idx;

    assign two_rec   = (fill_reg >= FW'(2));
    assign rest_sum  = sum_reg - SUM_W'(item_reg.packet_bytes);
    assign num_i     = NUM_W'(item_reg.packet_bytes) * NUM_W'(lbm_pkg::RATE_SCALE);
    assign num_a     = NUM_W'(rest_sum) * NUM_W'(lbm_pkg::RATE_SCALE);
    assign den_i     = item_reg.arrival_us - tprev_reg;
    assign den_a     = item_reg.arrival_us - toldest_reg;
    assign div_start = (state_reg == S_MUL);
    assign avg_val   = two_rec ? quot_a : '0;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign load_out  = (state_reg == S_OUT) && (!rpt_valid_reg || !rpt_stall);

    lbm_ram #(.WIDTH(lbm_pkg::BYTES_W), .DEPTH(AVG_WINDOW)) u_size_ram (
        .clk   (clk),
        .we    (state_reg == S_UPD),
        .waddr (head_reg),
        .wdata (item_reg.packet_bytes),
        .raddr (head_reg),
        .rdata (size_rdata)
    );

    lbm_ram #(.WIDTH(lbm_pkg::TIME_W), .DEPTH(AVG_WINDOW)) u_time_ram (
        .clk   (clk),
        .we    (state_reg == S_UPD),
        .waddr (head_reg),
        .wdata (item_reg.arrival_us),
        .raddr (time_raddr),
        .rdata (time_rdata)
    );

    lbm_ram #(.WIDTH(lbm_pkg::RATE_W), .DEPTH(PEAK_WINDOW)) u_rate_ram (
        .clk   (clk),
        .we    (state_reg == S_WRR),
        .waddr (rhead_reg),
        .wdata (avg_val),
        .raddr (scan_reg[PAW-1:0]),
        .rdata (rate_rdata)
    );

    lbm_div #(.NUM_W(NUM_W)) u_div_inst (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_i),
        .den   (den_i),
        .busy  (busy_i),
        .quot  (quot_i)
    );

    lbm_div #(.NUM_W(NUM_W)) u_div_avg (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_a),
        .den   (den_a),
        .busy  (busy_a),
        .quot  (quot_a)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_valid) state_next = S_RDA;
            S_RDA:  state_next = S_RDB;
            S_RDB:  state_next = S_UPD;
            S_UPD:  state_next = S_MUL;
            S_MUL:  state_next = S_DIV;
            S_DIV:  if (!busy_i && !busy_a) state_next = S_WRR;
            S_WRR:  state_next = S_SCAN;
            S_SCAN: if (scan_reg == rfill_reg && !scan_vld_reg) state_next = S_OUT;
            S_OUT:  if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            rhead_reg     <= '0;
            rfill_reg     <= '0;
            scan_reg      <= '0;
            scan_vld_reg  <= 1'b0;
            rpt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_UPD)
            begin
                sum_reg  <= sum_reg - (full ? SUM_W'(old_size_reg) : '0)
                          + SUM_W'(item_reg.packet_bytes);
                head_reg <= head_new;
                fill_reg <= fill_new;
            end
            if (state_reg == S_WRR)
            begin
                rhead_reg    <= (rhead_reg == RHEAD_LAST) ? '0 : rhead_reg + 1'b1;
                rfill_reg    <= (rfill_reg == RFILL_FULL) ? rfill_reg : rfill_reg + 1'b1;
                scan_reg     <= '0;
                scan_vld_reg <= 1'b0;
            end
            if (state_reg == S_SCAN)
            begin
                scan_vld_reg <= (scan_reg != rfill_reg);
                if (scan_reg != rfill_reg)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            if (load_out)
            begin
                rpt_valid_reg <= 1'b1;
            end
            else if (!rpt_stall)
            begin
                rpt_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == S_RDB)
        begin
            old_size_reg <= size_rdata;
            tprev_reg    <= time_rdata;
        end
        if (state_reg == S_UPD)
        begin
            toldest_reg <= time_rdata;
        end
        if (state_reg == S_WRR)
        begin
            inst_reg <= two_rec ? quot_i : '0;
            avg_reg  <= avg_val;
            peak_reg <= '0;
        end
        if (state_reg == S_SCAN && scan_vld_reg && rate_rdata > peak_reg)
        begin
            peak_reg <= rate_rdata;
        end
        if (load_out)
        begin
            rpt_reg <= '{instant_rate: inst_reg,
                         average_rate: avg_reg,
                         peak_rate:    peak_reg,
                         packet_count: item_reg.packet_count,
                         byte_total:   item_reg.byte_total,
                         window_fill:  lbm_pkg::FILL_W'(fill_reg)};
        end
    end

    assign rpt_valid = rpt_valid_reg;
    assign rpt       = rpt_reg;

endmodule

`default_nettype wire

### verif/tb_link_bandwidth_meter.sv
// Testbench for the link bandwidth meter: drives packet records, predicts each
// report from an internal model of the window, peak and counters, and compares.
// Depends on lbm_pkg and link_bandwidth_meter.
`timescale 1ns / 100ps

module tb_link_bandwidth_meter;

    localparam int AVG_N  = 64;
    localparam int PEAK_N = 64;

    logic               clk;
    logic               rst_n;
    logic               pkt_valid;
    logic               pkt_stall;
    lbm_pkg::pkt_item_t pkt;
    logic               rpt_valid;
    logic               rpt_stall;
    lbm_pkg::rpt_item_t rpt;

    link_bandwidth_meter #(.AVG_WINDOW(AVG_N), .PEAK_WINDOW(PEAK_N)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .pkt_valid(pkt_valid), .pkt_stall(pkt_stall), .pkt(pkt),
        .rpt_valid(rpt_valid), .rpt_stall(rpt_stall), .rpt(rpt)
    );

    // meter model state
    logic [lbm_pkg::BYTES_W-1:0] m_size [AVG_N];
    logic [lbm_pkg::TIME_W-1:0]  m_time [AVG_N];
    logic [lbm_pkg::RATE_W-1:0]  m_rates [PEAK_N];
    int                          m_head;
    int                          m_fill;
    logic [63:0]                 m_sum;
    int                          m_rhead;
    int                          m_rfill;
    logic [lbm_pkg::COUNT_W-1:0] m_count;
    logic [63:0]                 m_bytes;

    lbm_pkg::rpt_item_t expected_reports [$];
    int                 errors;
    int                 stall_mode;
    logic [lbm_pkg::TIME_W-1:0] clock_us;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [lbm_pkg::RATE_W-1:0] rate_of(logic [63:0] b,
                                                           logic [lbm_pkg::TIME_W-1:0] us);
        logic [127:0] q;
        if (us == 0)
            return '0;
        q = ({64'd0, b} * 128'd256000) / {80'd0, us};
        if (q > {88'd0, lbm_pkg::RATE_MAX})
            return lbm_pkg::RATE_MAX;
        return q[lbm_pkg::RATE_W-1:0];
    endfunction

    task automatic predict_report(lbm_pkg::pkt_item_t p);
        lbm_pkg::rpt_item_t r;
        int prev, oldest;
        logic [lbm_pkg::RATE_W-1:0] avg, peak;
        prev = (m_head == 0) ? AVG_N - 1 : m_head - 1;
        if (m_fill >= AVG_N)
            m_sum -= m_size[m_head];
        else
            m_fill++;
        m_size[m_head] = p.packet_bytes;
        m_time[m_head] = p.arrival_us;
        m_head = (m_head + 1) % AVG_N;
        m_sum += p.packet_bytes;
        if (m_count != lbm_pkg::COUNT_MAX)
            m_count++;
        m_bytes += p.packet_bytes;
        if (m_bytes > {16'd0, lbm_pkg::TOTAL_MAX})
            m_bytes = {16'd0, lbm_pkg::TOTAL_MAX};
        r = '0;
        avg = '0;
        if (m_fill >= 2)
        begin
            r.instant_rate = rate_of(p.packet_bytes, p.arrival_us - m_time[prev]);
            oldest = (m_head + AVG_N - m_fill) % AVG_N;
            avg = rate_of(m_sum - p.packet_bytes, p.arrival_us - m_time[oldest]);
        end
        m_rates[m_rhead] = avg;
        m_rhead = (m_rhead + 1) % PEAK_N;
        if (m_rfill < PEAK_N)
            m_rfill++;
        peak = '0;
        for (int i = 0; i < m_rfill; i++)
            if (m_rates[i] > peak)
                peak = m_rates[i];
        r.average_rate = avg;
        r.peak_rate = peak;
        r.packet_count = m_count;
        r.byte_total = m_bytes[lbm_pkg::TIME_W-1:0];
        r.window_fill = m_fill[lbm_pkg::FILL_W-1:0];
        expected_reports.push_back(r);
    endtask

    task automatic send_packet(logic [lbm_pkg::BYTES_W-1:0] b, logic [lbm_pkg::TIME_W-1:0] t);
        lbm_pkg::pkt_item_t p;
        p.packet_bytes = b;
        p.arrival_us = t;
        pkt <= p;
        pkt_valid <= 1'b1;
        @(posedge clk);
        while (pkt_stall)
            @(posedge clk);
        predict_report(p);
        @(negedge clk);
    endtask

    task automatic idle_sender();
        pkt_valid <= 1'b0;
        repeat ($urandom_range(1, 150))
            @(negedge clk);
    endtask

    // compare each report with the oldest prediction
    always @(posedge clk)
    begin
        lbm_pkg::rpt_item_t e;
        if (rst_n && rpt_valid && !rpt_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%t unexpected report actual %h", $time, rpt);
                errors++;
            end
            else
            begin
                e = expected_reports.pop_front();
                if (rpt !== e)
                begin
                    $display("%t mismatch expected %h actual %h", $time, e, rpt);
                    $display("  inst %h/%h avg %h/%h peak %h/%h", e.instant_rate,
                        rpt.instant_rate, e.average_rate, rpt.average_rate,
                        e.peak_rate, rpt.peak_rate);
                    $display("  count %h/%h total %h/%h fill %0d/%0d", e.packet_count,
                        rpt.packet_count, e.byte_total, rpt.byte_total,
                        e.window_fill, rpt.window_fill);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        case (stall_mode)
            0: rpt_stall <= 1'b0;
            1: rpt_stall <= ($urandom_range(0, 3) == 0);
            2: rpt_stall <= ($urandom_range(0, 1) == 0);
            default: rpt_stall <= ($urandom_range(0, 9) != 0);
        endcase
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 3);
    end

    task automatic test_directed();
        send_packet(16'd0, 48'd0);
        send_packet(16'hFFFF, 48'd0);
        send_packet(16'hFFFF, 48'd1);
        send_packet(16'd1, 48'd1);
        send_packet(16'h8000, 48'd1000);
        send_packet(16'hFFFF, lbm_pkg::TOTAL_MAX);
        send_packet(16'd64, 48'd5);
        send_packet(16'h5555, 48'hAAAA_AAAA_AAAA);
        send_packet(16'hAAAA, 48'h5555_5555_5555);
        send_packet(16'd1500, 48'h5555_5555_5560);
        for (int i = 0; i < 10; i++)
            send_packet(16'd100, 48'h5555_5555_5570);
        clock_us = 48'h5555_5555_6000;
    endtask

    // runs past the peak window so that old averages leave the peak ring one per item
    task automatic test_peak_window();
        for (int i = 0; i < 140; i++)
        begin
            clock_us += (i % 3 == 0) ? 48'd1000 : 48'd10;
            send_packet((i < 70) ? 16'd1000 : 16'd10, clock_us);
            if ($urandom_range(0, 15) == 0)
                idle_sender();
        end
    endtask

    task automatic test_random_traffic();
        int n;
        logic [lbm_pkg::BYTES_W-1:0] b;
        n = 0;
        while (n < 1000)
        begin
            repeat ($urandom_range(1, 30))
            begin
                case ($urandom_range(0, 9))
                    0: b = 16'($urandom);
                    1: b = 16'hFFFF;
                    2: b = 16'd0;
                    default: b = 16'($urandom_range(40, 1500));
                endcase
                case ($urandom_range(0, 19))
                    0: clock_us = 48'({$urandom, $urandom});
                    1: clock_us = clock_us;
                    2: clock_us -= 48'($urandom_range(1, 100));
                    3: clock_us += 48'({$urandom, $urandom} >> $urandom_range(0, 40));
                    default: clock_us += 48'($urandom_range(1, 2000));
                endcase
                send_packet(b, clock_us);
                n++;
            end
            idle_sender();
        end
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        pkt_valid = 1'b0;
        pkt = '0;
        rpt_stall = 1'b0;
        stall_mode = 0;
        errors = 0;
        m_head = 0; m_fill = 0; m_sum = 0; m_rhead = 0; m_rfill = 0;
        m_count = '0; m_bytes = '0;
        clock_us = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_peak_window();
        stall_mode = 1;
        test_random_traffic();
        pkt_valid <= 1'b0;
        stall_mode = 0;
        waited = 0;
        while (expected_reports.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (300) @(posedge clk);
        if (errors == 0 && expected_reports.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### filelist.f
hdl/lbm_pkg.sv
hdl/lbm_ram.sv
hdl/lbm_div.sv
hdl/lbm_front.sv
hdl/lbm_back.sv
hdl/link_bandwidth_meter.sv
verif/tb_link_bandwidth_meter.sv
